[rtl/uart_idle_timeout_frame_buffer_assert.svh]
// Assertion macros for the UART idle-timeout frame buffer.
`ifndef UART_IDLE_TIMEOUT_FRAME_BUFFER_ASSERT_SVH
`define UART_IDLE_TIMEOUT_FRAME_BUFFER_ASSERT_SVH

`ifndef ASSERT_OFF
`define UITFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UITFB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define UITFB_ASSERT(lbl, prop, msg)
`define UITFB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/uitfb_pkg.sv]
`timescale 1ns / 1ps

package uitfb_pkg;

  localparam int BYTE_W = 8;
  localparam int GAP_W  = 9;
  localparam int LEN_W  = 7;
  localparam int MS_W   = 10;
  localparam int CMD_W  = 3;

  localparam logic [GAP_W-1:0] GAP_MAX   = 9'd500;
  localparam logic [GAP_W-1:0] GAP_RESET = 9'd104;

  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE  = 3'd0,
    CMD_TICK     = 3'd1,
    CMD_TX_WRITE = 3'd2,
    CMD_TX_READY = 3'd3,
    CMD_TX_DONE  = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

endpackage

[rtl/uitfb_ram.sv]
`timescale 1ns / 1ps

module uitfb_ram #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [uitfb_pkg::BYTE_W-1:0]  wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [uitfb_pkg::BYTE_W-1:0]  rdata
);

  logic [uitfb_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/uart_idle_timeout_frame_buffer.sv]
`timescale 1ns / 1ps
// UART receive framing by idle gap, with a transmit byte FIFO.
// Commands enter on start/in_* and are taken when start is high and busy is low.
// Every command produces one result except a frame read that delivers bytes,
// which produces one result per byte, the final one flagged by out_last.
// Results appear for one cycle with out_valid; the receiver cannot stall them.
// Receive byte, tick, transmit write, transmit complete and failed reads show
// their result in the cycle after acceptance and busy stays low, so a command
// can be issued every cycle.
// Transmit ready with a queued byte passes through S_POP, where the registered
// read of the transmit memory supplies the byte while busy is high. A frame
// read of t bytes first primes the receive memory read, then delivers one byte
// per cycle while busy is high. The gap limit is written on cfg_valid (cfg_ready
// is always high); the user is to do so only while idle, as the block does not
// enforce it. Values above 500 saturate. Reset (rst_n low, synchronous) empties
// both buffers, clears the status flags and the timer, and loads a gap limit of
// 104. Buffer contents are not cleared; no sweep is needed after reset.

`include "uart_idle_timeout_frame_buffer_assert.svh"

module uart_idle_timeout_frame_buffer #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [uitfb_pkg::CMD_W-1:0]    in_cmd,
  input  logic [uitfb_pkg::BYTE_W-1:0]   in_byte_in,
  input  logic [uitfb_pkg::MS_W-1:0]     in_tick_ms,
  input  logic [uitfb_pkg::LEN_W-1:0]    in_req_len,
  output logic                           out_valid,
  output logic [uitfb_pkg::BYTE_W-1:0]   out_byte_out,
  output logic                           out_byte_valid,
  output logic [uitfb_pkg::LEN_W-1:0]    out_frame_len,
  output logic                           out_last,
  output logic                           out_accepted,
  output logic                           out_receiving,
  output logic                           out_frame_done,
  output logic                           out_sending,
  output logic                           out_idle,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uitfb_pkg::GAP_W-1:0]    cfg_data
);

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int TX_PW = $clog2(2 * TX_DEPTH);
  localparam logic [RX_CW-1:0] RX_FULL  = RX_CW'(RX_DEPTH);
  localparam logic [TX_PW-1:0] TX_WRAP  = TX_PW'(2 * TX_DEPTH - 1);
  localparam logic [TX_PW-1:0] TX_HALF  = TX_PW'(TX_DEPTH);
  localparam logic [TX_PW:0]   TX_SPAN  = (TX_PW + 1)'(2 * TX_DEPTH);
  localparam logic [TX_PW:0]   TX_FULL  = (TX_PW + 1)'(TX_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_READ
  } state_t;

  state_t                          state_r, state_nxt;
  logic [uitfb_pkg::GAP_W-1:0]     gap_limit_r, gap_limit_nxt;
  logic [uitfb_pkg::GAP_W-1:0]     gap_timer_r, gap_timer_nxt;
  logic [RX_CW-1:0]                rx_count_r, rx_count_nxt;
  logic                            recv_r, recv_nxt;
  logic                            done_r, done_nxt;
  logic [TX_PW-1:0]                tx_head_r, tx_head_nxt;
  logic [TX_PW-1:0]                tx_tail_r, tx_tail_nxt;
  logic                            sending_r, sending_nxt;
  logic                            idle_r, idle_nxt;
  logic [uitfb_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [uitfb_pkg::LEN_W-1:0]     idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [uitfb_pkg::BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic                            out_bvalid_r, out_bvalid_nxt;
  logic [uitfb_pkg::LEN_W-1:0]     out_len_r, out_len_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_acc_r, out_acc_nxt;

  logic                            rx_we;
  logic [RX_AW-1:0]                rx_raddr;
  logic [uitfb_pkg::BYTE_W-1:0]    rx_rdata;
  logic                            tx_we;
  logic [uitfb_pkg::BYTE_W-1:0]    tx_rdata;
  logic [TX_AW-1:0]                tx_head_slot, tx_tail_slot;
  logic [TX_PW:0]                  tx_used;
  logic                            tx_full, tx_empty;
  logic [uitfb_pkg::LEN_W-1:0]     rx_count_ext, take_len;
  logic [uitfb_pkg::LEN_W-1:0]     idx_inc;
  uitfb_pkg::cmd_t                 cmd;

  function automatic logic [TX_PW-1:0] tx_inc(input logic [TX_PW-1:0] p);
    return (p == TX_WRAP) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TX_AW-1:0] tx_slot(input logic [TX_PW-1:0] p);
    logic [TX_PW-1:0] s;
    s = (p >= TX_HALF) ? p - TX_HALF : p;
    return s[TX_AW-1:0];
  endfunction

  assign cmd          = uitfb_pkg::cmd_t'(in_cmd);
  assign tx_head_slot = tx_slot(tx_head_r);
  assign tx_tail_slot = tx_slot(tx_tail_r);
  // Pointers run modulo twice the depth so full and empty are told apart.
  assign tx_used      = (tx_tail_r >= tx_head_r)
                        ? {1'b0, tx_tail_r} - {1'b0, tx_head_r}
                        : {1'b0, tx_tail_r} + TX_SPAN - {1'b0, tx_head_r};
  assign tx_full      = (tx_used == TX_FULL);
  assign tx_empty     = (tx_head_r == tx_tail_r);
  assign rx_count_ext = uitfb_pkg::LEN_W'(rx_count_r);
  assign take_len     = (rx_count_ext < in_req_len) ? rx_count_ext : in_req_len;
  assign idx_inc      = idx_r + 1'b1;
  // The next frame byte is read ahead while the current one is delivered.
  assign rx_raddr     = (state_r == S_READ) ? idx_inc[RX_AW-1:0] : '0;

  uitfb_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_count_r[RX_AW-1:0]),
    .wdata (in_byte_in),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  uitfb_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_tail_slot),
    .wdata (in_byte_in),
    .raddr (tx_head_slot),
    .rdata (tx_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    gap_limit_nxt  = gap_limit_r;
    gap_timer_nxt  = gap_timer_r;
    rx_count_nxt   = rx_count_r;
    recv_nxt       = recv_r;
    done_nxt       = done_r;
    tx_head_nxt    = tx_head_r;
    tx_tail_nxt    = tx_tail_r;
    sending_nxt    = sending_r;
    idle_nxt       = idle_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_byte_nxt   = '0;
    out_bvalid_nxt = 1'b0;
    out_len_nxt    = '0;
    out_last_nxt   = 1'b1;
    out_acc_nxt    = 1'b0;
    rx_we          = 1'b0;
    tx_we          = 1'b0;

    if (cfg_valid) begin
      gap_limit_nxt = (cfg_data > uitfb_pkg::GAP_MAX) ? uitfb_pkg::GAP_MAX : cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (cmd)
            uitfb_pkg::CMD_RX_BYTE: begin
              out_valid_nxt = 1'b1;
              if (rx_count_r != RX_FULL) begin
                rx_we         = 1'b1;
                rx_count_nxt  = rx_count_r + 1'b1;
                recv_nxt      = 1'b1;
                done_nxt      = 1'b0;
                gap_timer_nxt = gap_limit_r;
                out_acc_nxt   = 1'b1;
              end
            end
            uitfb_pkg::CMD_TICK: begin
              out_valid_nxt = 1'b1;
              idle_nxt      = !sending_r;
              if (gap_timer_r != '0) begin
                if (in_tick_ms >= uitfb_pkg::MS_W'(gap_timer_r)) begin
                  gap_timer_nxt = '0;
                  recv_nxt      = 1'b0;
                  done_nxt      = 1'b1;
                end else begin
                  gap_timer_nxt = gap_timer_r - in_tick_ms[uitfb_pkg::GAP_W-1:0];
                end
              end
            end
            uitfb_pkg::CMD_TX_WRITE: begin
              out_valid_nxt = 1'b1;
              sending_nxt   = 1'b1;
              if (!tx_full) begin
                tx_we       = 1'b1;
                tx_tail_nxt = tx_inc(tx_tail_r);
                out_acc_nxt = 1'b1;
              end
            end
            uitfb_pkg::CMD_TX_READY: begin
              if (tx_empty) begin
                out_valid_nxt = 1'b1;
                tx_head_nxt   = '0;
                tx_tail_nxt   = '0;
              end else begin
                tx_head_nxt = tx_inc(tx_head_r);
                sending_nxt = 1'b1;
                state_nxt   = S_POP;
              end
            end
            uitfb_pkg::CMD_TX_DONE: begin
              out_valid_nxt = 1'b1;
              sending_nxt   = 1'b0;
            end
            uitfb_pkg::CMD_READ: begin
              if (gap_timer_r != '0 || rx_count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                rx_count_nxt = '0;
                done_nxt     = 1'b0;
                if (take_len == '0) begin
                  out_valid_nxt = 1'b1;
                end else begin
                  len_nxt   = take_len;
                  idx_nxt   = '0;
                  state_nxt = S_READ;
                end
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = tx_rdata;
        out_bvalid_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = rx_rdata;
        out_bvalid_nxt = 1'b1;
        out_len_nxt    = len_r;
        out_last_nxt   = (idx_inc == len_r);
        idx_nxt        = idx_inc;
        if (idx_inc == len_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gap_limit_r <= uitfb_pkg::GAP_RESET;
      gap_timer_r <= '0;
      rx_count_r  <= '0;
      recv_r      <= 1'b0;
      done_r      <= 1'b0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      sending_r   <= 1'b0;
      idle_r      <= 1'b0;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gap_limit_r <= gap_limit_nxt;
      gap_timer_r <= gap_timer_nxt;
      rx_count_r  <= rx_count_nxt;
      recv_r      <= recv_nxt;
      done_r      <= done_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      sending_r   <= sending_nxt;
      idle_r      <= idle_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r   <= out_byte_nxt;
    out_bvalid_r <= out_bvalid_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
    out_acc_r    <= out_acc_nxt;
  end

  // Status flags change only at an accepted command, so during a result's
  // cycle they still hold the values left by the command that produced it.
  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_byte_out   = out_byte_r;
  assign out_byte_valid = out_bvalid_r;
  assign out_frame_len  = out_len_r;
  assign out_last       = out_last_r;
  assign out_accepted   = out_acc_r;
  assign out_receiving  = recv_r;
  assign out_frame_done = done_r;
  assign out_sending    = sending_r;
  assign out_idle       = idle_r;

  `UITFB_ASSERT_NEVER(a_rx_count_range, rx_count_r > RX_FULL, "rx count beyond depth")
  `UITFB_ASSERT_NEVER(a_tx_used_range, tx_used > TX_FULL, "tx fifo beyond depth")
  `UITFB_ASSERT(a_done_timer, done_r |-> gap_timer_r == '0, "frame done with timer running")
  `UITFB_ASSERT(a_burst_gapless, out_valid && !out_last |=> out_valid, "frame burst broken")

endmodule
